// ----- design/fhrt_pkg.sv -----
// ----------------------------------------------------------------------------
// fhrt_pkg: shared types and constants for the frame history ring
// Transaction payloads, operation codes, ring geometry and the constants of
// the samples-to-milliseconds turnaround conversion.
// ----------------------------------------------------------------------------
package fhrt_pkg;

  // Ring geometry. Depth stays a power of two not above 1024 so that every row
  // is reachable through the 10-bit read row field.
  localparam int unsigned Depth  = 1024;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CountW = AddrW + 1;

  // Operation codes carried in the mode field.
  localparam logic [1:0] ModeAppend = 2'd0;
  localparam logic [1:0] ModeRead   = 2'd1;
  localparam logic [1:0] ModeClear  = 2'd2;

  // 12000 samples per second, 1000 ms per second: ms = floor(elapsed / 12).
  localparam int unsigned SamplesPerSec = 12000;
  localparam int unsigned MsPerSec      = 1000;
  localparam int unsigned SamplesPerMs  = SamplesPerSec / MsPerSec;

  // Elapsed values at or above this limit give a quotient past 32 bits.
  localparam logic [47:0] TurnSatLimit = 48'(SamplesPerMs) << 32;

  // Divide by three as multiply and shift, split in two 17-bit halves.
  localparam int unsigned HalfW      = 17;
  localparam int unsigned Div3HiShft = 18;
  localparam int unsigned Div3LoShft = 20;
  localparam logic [16:0] Div3HiMul  = 17'(((1 << Div3HiShft) + 2) / 3);
  localparam logic [18:0] Div3LoMul  = 19'(((1 << Div3LoShft) + 2) / 3);

  typedef struct packed {
    logic [1:0]        mode;
    logic [47:0]       frame_time;
    logic [7:0]        frame_kind;
    logic              direction;
    logic [7:0]        quality_in;
    logic signed [7:0] snr_in;
    logic [9:0]        read_row;
  } fhrt_in_t;

  typedef struct packed {
    logic [9:0]        newest_row;
    logic              dropped_oldest;
    logic              hit;
    logic [47:0]       rec_time;
    logic [7:0]        rec_kind;
    logic              rec_direction;
    logic [7:0]        rec_quality;
    logic signed [7:0] rec_snr;
    logic              rec_turn_valid;
    logic [31:0]       rec_turn_ms;
  } fhrt_out_t;

endpackage

// ----- design/frame_history_ring_with_turnaround.sv -----
// ----------------------------------------------------------------------------
// frame_history_ring_with_turnaround: frame record ring with turnaround timing
// Pipeline: input register, four work stages, memory read register.
// Throughput: one transaction per cycle while the output is not stalled; the
//   single-port record memory takes one write or one read per transaction,
//   and stages advance past bubbles.
// Reset: asynchronous, clears the ring pointers and pending-reception state;
//   the record memory itself is never cleared.
// ----------------------------------------------------------------------------
module frame_history_ring_with_turnaround
  import fhrt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fhrt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fhrt_out_t out_data_o
);

  // Work record that travels from stage 2 to stage 5.
  typedef struct packed {
    logic [1:0]       mode;
    logic [47:0]      frame_time;
    logic [7:0]       frame_kind;
    logic             direction;
    logic [7:0]       quality;
    logic [7:0]       snr;
    logic             turn_valid;
    logic             turn_sat;
    logic [HalfW-1:0] div_hi;     // elapsed / 4, upper half
    logic [HalfW-1:0] div_lo;     // elapsed / 4, lower half
    logic [HalfW-1:0] quo_hi;     // div_hi / 3
    logic [1:0]       rem_hi;     // div_hi % 3
    logic [31:0]      turn_ms;
    logic [AddrW-1:0] addr;       // physical memory row
    logic             hit;
    logic [9:0]       newest_row;
    logic             dropped;
  } fhrt_work_t;

  // --------------------------------------------------------------------------
  // Ring state: updated as a transaction leaves the input register, so every
  // transaction sees the state left by the one before it.
  // --------------------------------------------------------------------------
  logic [AddrW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic [47:0]       last_rx_q, last_rx_d;
  logic              pending_q, pending_d;

  // Stage valids and handshake-side readiness.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic adv2;

  fhrt_in_t   s1_q;
  fhrt_work_t st2_d, st2_q, st3_d, st3_q, st4_d, st4_q, st5_d, st5_q;

  // Output stage: op summary plus the registered memory read data.
  logic [1:0]  s6_mode_q;
  logic        s6_hit_q;
  logic [9:0]  s6_newest_q;
  logic        s6_dropped_q;
  logic [56:0] rd_a_q;
  logic [48:0] rd_b_q;

  // Record memories: time/kind/direction and quality/snr/turnaround.
  logic [56:0] mem_a [Depth];
  logic [48:0] mem_b [Depth];

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor moves on,
  // so the input keeps flowing into bubbles while a result waits.
  // --------------------------------------------------------------------------
  always_comb begin
    rdy6 = !v6_q || !out_stall_i;
    rdy5 = !v5_q || rdy6;
    rdy4 = !v4_q || rdy5;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    adv2 = v1_q && rdy2;
  end

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 -> 2: decode the operation against the ring state, measure the
  // elapsed time since the last reception and split elapsed / 4 into halves.
  // --------------------------------------------------------------------------
  logic              full;
  logic [47:0]       elapsed;
  logic [AddrW:0]    rd_sum;
  logic [AddrW-1:0]  rd_base;
  logic [CountW-1:0] count_inc;

  always_comb begin
    full      = (count_q >= CountW'(Depth));
    elapsed   = s1_q.frame_time - last_rx_q;
    count_inc = full ? count_q : count_q + CountW'(1);
    rd_base   = full ? head_q : '0;
    rd_sum    = {1'b0, rd_base} + (AddrW + 1)'(s1_q.read_row);
    if (rd_sum >= (AddrW + 1)'(Depth)) begin
      rd_sum = rd_sum - (AddrW + 1)'(Depth);
    end

    st2_d            = '0;
    st2_d.mode       = s1_q.mode;
    st2_d.frame_time = s1_q.frame_time;
    st2_d.frame_kind = s1_q.frame_kind;
    st2_d.direction  = s1_q.direction;
    st2_d.quality    = s1_q.quality_in;
    st2_d.snr        = s1_q.snr_in;
    st2_d.turn_valid = s1_q.direction && pending_q && (s1_q.frame_time > last_rx_q);
    st2_d.turn_sat   = (elapsed >= TurnSatLimit);
    st2_d.div_hi     = elapsed[2*HalfW+1:HalfW+2];
    st2_d.div_lo     = elapsed[HalfW+1:2];
    st2_d.newest_row = 10'(count_inc - CountW'(1));
    st2_d.dropped    = full;
    st2_d.hit        = (CountW'(s1_q.read_row) < count_q);
    st2_d.addr       = (s1_q.mode == ModeAppend) ? head_q : rd_sum[AddrW-1:0];

    head_d    = head_q;
    count_d   = count_q;
    last_rx_d = last_rx_q;
    pending_d = pending_q;
    unique case (s1_q.mode)
      ModeAppend: begin
        // A transmit consumes any pending reception; a reception arms one.
        if (s1_q.direction) begin
          pending_d = 1'b0;
        end else begin
          last_rx_d = s1_q.frame_time;
          pending_d = 1'b1;
        end
        head_d  = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + AddrW'(1);
        count_d = count_inc;
      end
      ModeClear: begin
        head_d    = '0;
        count_d   = '0;
        last_rx_d = '0;
        pending_d = 1'b0;
      end
      default: begin
        // Read and the unused code leave the ring untouched.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      last_rx_q <= '0;
      pending_q <= 1'b0;
    end else if (adv2) begin
      head_q    <= head_d;
      count_q   <= count_d;
      last_rx_q <= last_rx_d;
      pending_q <= pending_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..5: floor(elapsed / 12) = floor(floor(elapsed / 4) / 3), done as
  // high-half quotient, high-half remainder, then low-half quotient.
  // --------------------------------------------------------------------------
  logic [2*HalfW-1:0] prod_hi;
  logic [HalfW-1:0]   three_qh;
  logic [HalfW+1:0]   lo_num;
  logic [37:0]        prod_lo;

  always_comb begin
    prod_hi      = st2_q.div_hi * Div3HiMul;
    st3_d        = st2_q;
    st3_d.quo_hi = HalfW'(prod_hi[2*HalfW-1:Div3HiShft]);
  end

  always_comb begin
    three_qh     = {st3_q.quo_hi[HalfW-2:0], 1'b0} + st3_q.quo_hi;
    st4_d        = st3_q;
    st4_d.rem_hi = 2'(st3_q.div_hi - three_qh);
  end

  always_comb begin
    lo_num  = {st4_q.rem_hi, st4_q.div_lo};
    prod_lo = lo_num * Div3LoMul;
    st5_d   = st4_q;
    // Saturate on a long gap; report nothing without a measured turnaround.
    priority if (!st4_q.turn_valid) begin
      st5_d.turn_ms = '0;
    end else if (st4_q.turn_sat) begin
      st5_d.turn_ms = '1;
    end else begin
      st5_d.turn_ms = {st4_q.quo_hi[31-HalfW:0], prod_lo[Div3LoShft+HalfW-1:Div3LoShft]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= in_data_i;
    if (adv2) st2_q <= st2_d;
    if (rdy3 && v2_q) st3_q <= st3_d;
    if (rdy4 && v3_q) st4_q <= st4_d;
    if (rdy5 && v4_q) st5_q <= st5_d;
  end

  // --------------------------------------------------------------------------
  // Stage 5 -> 6: one memory access per transaction. Writes and reads share
  // this stage, so a read always sees every earlier append in full.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      if (st5_q.mode == ModeAppend) begin
        mem_a[st5_q.addr] <= {st5_q.direction, st5_q.frame_kind, st5_q.frame_time};
        mem_b[st5_q.addr] <= {st5_q.turn_ms, st5_q.turn_valid, st5_q.snr, st5_q.quality};
      end
      rd_a_q       <= mem_a[st5_q.addr];
      rd_b_q       <= mem_b[st5_q.addr];
      s6_mode_q    <= st5_q.mode;
      s6_hit_q     <= st5_q.hit;
      s6_newest_q  <= st5_q.newest_row;
      s6_dropped_q <= st5_q.dropped;
    end
  end

  // --------------------------------------------------------------------------
  // Result: append reports ring position, a hit read reports the record,
  // everything else is all zeros.
  // --------------------------------------------------------------------------
  assign out_valid_o = v6_q;

  always_comb begin
    out_data_o = '0;
    unique case (s6_mode_q)
      ModeAppend: begin
        out_data_o.newest_row     = s6_newest_q;
        out_data_o.dropped_oldest = s6_dropped_q;
      end
      ModeRead: begin
        if (s6_hit_q) begin
          out_data_o.hit            = 1'b1;
          out_data_o.rec_time       = rd_a_q[47:0];
          out_data_o.rec_kind       = rd_a_q[55:48];
          out_data_o.rec_direction  = rd_a_q[56];
          out_data_o.rec_quality    = rd_b_q[7:0];
          out_data_o.rec_snr        = rd_b_q[15:8];
          out_data_o.rec_turn_valid = rd_b_q[16];
          out_data_o.rec_turn_ms    = rd_b_q[48:17];
        end
      end
      default: begin
        // Clear and the unused code give an empty result.
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("held count exceeds ring depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 && (s1_q.mode == ModeClear) |=> (count_q == '0) && (head_q == '0) && !pending_q)
    else $error("clear did not empty the ring");

  a_tx_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 && (s1_q.mode == ModeAppend) && s1_q.direction |=> !pending_q)
    else $error("transmit append left a reception pending");

  a_append_no_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (s6_mode_q == ModeAppend) |-> !out_data_o.hit &&
      (out_data_o.rec_turn_ms == '0))
    else $error("append result carries record fields");

endmodule
